// ===== hdl/vp8rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vp8rtp_pkg
// Shared types and constants for the VP8 RTP payload extractor: beat
// structs, result status codes and payload descriptor walk phases.
// ----------------------------------------------------------------------------
package vp8rtp_pkg;

    // Default largest packet length in bytes
    localparam int MAX_PACKET_DEFAULT = 2048;

    // Result status codes
    localparam logic [1:0] ST_TAKEN   = 2'd0;  // payload range valid
    localparam logic [1:0] ST_EMPTY   = 2'd1;  // nothing past header and padding
    localparam logic [1:0] ST_OVERRUN = 2'd2;  // descriptor runs past payload
    localparam logic [1:0] ST_DROPPED = 2'd3;  // truncated or too long

    // Fixed RTP header length before CSRC entries
    localparam int RTP_FIXED_BYTES = 12;

    // One packet byte with its framing marks
    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_last;
        logic       frame_last;
    } in_beat_t;

    // One per-packet report
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] payload_start;
        logic [11:0] payload_end;
        logic        frame_done;
        logic        frame_nonempty;
        logic [31:0] frame_timestamp;
        logic [6:0]  frame_payload_type;
    } out_beat_t;

    // VP8 payload descriptor walk phases
    typedef enum logic [6:0] {
        PH_FIRST = 7'b0000001,  // waiting for first descriptor byte
        PH_EXT   = 7'b0000010,  // extension byte (I, L, T, K)
        PH_PID1  = 7'b0000100,  // first picture id byte
        PH_PID2  = 7'b0001000,  // second picture id byte
        PH_TL0   = 7'b0010000,  // TL0PICIDX byte
        PH_TK    = 7'b0100000,  // TID/KEYIDX byte
        PH_DONE  = 7'b1000000   // descriptor complete
    } desc_phase_t;

    // Descriptor flag bits kept from the extension byte
    localparam int DF_I  = 2;
    localparam int DF_L  = 1;
    localparam int DF_TK = 0;

endpackage

// ===== hdl/vp8_rtp_payload_extractor.sv =====
// ----------------------------------------------------------------------------
// vp8_rtp_payload_extractor
// Parses RTP packets carrying VP8, one byte per beat: RTP header, CSRC list,
// header extension, padding and the VP8 payload descriptor. Reports the
// payload byte range or a drop reason per packet, and a frame summary on
// the packet that closes a frame.
//
//   Channel  Signals                        Beat
//   -------  -----------------------------  ----------------------------------
//   pkt      pkt_valid, pkt_stall, pkt_beat one packet byte with framing marks
//   rpt      rpt_valid, rpt_stall, rpt_beat one report per packet-final byte
//
// Takes one byte every cycle while pkt_stall is low. A beat waits in the input
// register, its state update and report are computed there, and the report
// is loaded into the result register when the beat moves on.
// pkt_stall rises only when a packet-final byte waits in the input register
// while the result register holds a report that rpt_stall is holding back.
// Reset clears all parse and frame state; the first packet starts at once.
// ----------------------------------------------------------------------------
module vp8_rtp_payload_extractor #(
    parameter int MAX_PACKET = vp8rtp_pkg::MAX_PACKET_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pkt_valid,
    output logic                 pkt_stall,
    input  vp8rtp_pkg::in_beat_t pkt_beat,
    output logic                 rpt_valid,
    input  logic                 rpt_stall,
    output vp8rtp_pkg::out_beat_t rpt_beat
);

    // Byte position width, able to hold MAX_PACKET itself
    localparam int PW = $clog2(MAX_PACKET + 1);
    // Size arithmetic width: header end plus a full padding count
    localparam int SW = PW + 2;
    // Header length with extension: up to 72 + 4 + 4 * 65535
    localparam int HW = 19;
    localparam logic [PW-1:0] MAX_POS = PW'(MAX_PACKET);
    localparam logic [HW-1:0] MAX_HDR = HW'(MAX_PACKET);

    // Input register
    logic                  in_valid_reg;
    vp8rtp_pkg::in_beat_t  in_beat_reg;

    // Result register
    logic                  rpt_valid_reg;
    vp8rtp_pkg::out_beat_t rpt_beat_reg;
    vp8rtp_pkg::out_beat_t rpt_beat_next;

    // Packet state
    logic [PW-1:0]           pos_reg, pos_next;
    logic [3:0]              csrc_reg, csrc_next;
    logic                    pad_flag_reg, pad_flag_next;
    logic                    ext_flag_reg, ext_flag_next;
    logic [7:0]              ext_hi_reg, ext_hi_next;
    logic [PW-1:0]           hdr_end_reg, hdr_end_next;
    vp8rtp_pkg::desc_phase_t phase_reg, phase_next;
    logic [PW-1:0]           desc_end_reg, desc_end_next;
    logic [2:0]              dflags_reg, dflags_next;

    // Frame state
    logic                    started_reg, started_next;
    logic [31:0]             ts_reg, ts_next;
    logic [6:0]              pt_reg, pt_next;
    logic                    any_reg, any_next;

    // Per-beat working values
    logic                    proc_fire;
    logic [7:0]              b;
    logic                    in_range;
    logic [PW-1:0]           base;
    logic [HW-1:0]           hdr_len;
    logic [SW-1:0]           size;
    logic [SW-1:0]           limit;
    logic [SW-1:0]           pend;
    logic [SW-1:0]           pstart;
    logic [7:0]              pad;

    // Phase after the picture id bytes
    function automatic vp8rtp_pkg::desc_phase_t after_pid(input logic [2:0] flags);
        vp8rtp_pkg::desc_phase_t ph;
        if (flags[vp8rtp_pkg::DF_L]) begin
            ph = vp8rtp_pkg::PH_TL0;
        end
        else if (flags[vp8rtp_pkg::DF_TK]) begin
            ph = vp8rtp_pkg::PH_TK;
        end
        else begin
            ph = vp8rtp_pkg::PH_DONE;
        end
        return ph;
    endfunction

    // Advance the held beat unless it is packet-final and the result side cannot take it
    assign proc_fire = in_valid_reg &&
                       (!in_beat_reg.packet_last || !rpt_valid_reg || !rpt_stall);
    assign pkt_stall = in_valid_reg && !proc_fire;

    assign rpt_valid = rpt_valid_reg;
    assign rpt_beat  = rpt_beat_reg;

    // Parse one byte and build the report
    always_comb
    begin
        b        = in_beat_reg.data_byte;
        in_range = pos_reg < MAX_POS;

        pos_next      = pos_reg;
        csrc_next     = csrc_reg;
        pad_flag_next = pad_flag_reg;
        ext_flag_next = ext_flag_reg;
        ext_hi_next   = ext_hi_reg;
        hdr_end_next  = hdr_end_reg;
        phase_next    = phase_reg;
        desc_end_next = desc_end_reg;
        dflags_next   = dflags_reg;
        started_next  = started_reg;
        ts_next       = ts_reg;
        pt_next       = pt_reg;
        any_next      = any_reg;

        // First header byte carries CSRC count, padding and extension bits
        if (pos_reg == '0) begin
            csrc_next     = b[3:0];
            pad_flag_next = b[5];
            ext_flag_next = b[4];
        end

        base    = PW'(vp8rtp_pkg::RTP_FIXED_BYTES) + PW'({csrc_next, 2'b00});
        hdr_len = HW'(base) + HW'(4) + HW'({ext_hi_reg, b, 2'b00});

        if (in_range) begin
            pos_next = pos_reg + PW'(1);

            // Capture payload type and timestamp of the frame's first packet
            if (!started_reg) begin
                if (pos_reg == PW'(1)) begin
                    pt_next = b[6:0];
                end
                if (pos_reg >= PW'(4) && pos_reg <= PW'(7)) begin
                    ts_next = {ts_reg[23:0], b};
                end
            end

            if (hdr_end_reg != '0) begin
                // Walk the payload descriptor
                if (pos_reg >= hdr_end_reg && phase_reg != vp8rtp_pkg::PH_DONE) begin
                    desc_end_next = pos_reg + PW'(1);
                    case (phase_reg)
                        vp8rtp_pkg::PH_FIRST:
                        begin
                            phase_next = b[7] ? vp8rtp_pkg::PH_EXT : vp8rtp_pkg::PH_DONE;
                        end
                        vp8rtp_pkg::PH_EXT:
                        begin
                            dflags_next = {b[7], b[6], b[5] | b[4]};
                            phase_next  = b[7] ? vp8rtp_pkg::PH_PID1
                                               : after_pid({b[7], b[6], b[5] | b[4]});
                        end
                        vp8rtp_pkg::PH_PID1:
                        begin
                            phase_next = b[7] ? vp8rtp_pkg::PH_PID2 : after_pid(dflags_reg);
                        end
                        vp8rtp_pkg::PH_PID2:
                        begin
                            phase_next = after_pid(dflags_reg);
                        end
                        vp8rtp_pkg::PH_TL0:
                        begin
                            phase_next = dflags_reg[vp8rtp_pkg::DF_TK] ? vp8rtp_pkg::PH_TK
                                                                       : vp8rtp_pkg::PH_DONE;
                        end
                        default:
                        begin
                            phase_next = vp8rtp_pkg::PH_DONE;
                        end
                    endcase
                end
            end
            else if (!ext_flag_next) begin
                // Header ends after the CSRC list
                if (pos_reg + PW'(1) == base) begin
                    hdr_end_next = base;
                end
            end
            else begin
                // Header extension: length word at base+2 and base+3
                if (pos_reg == base + PW'(2)) begin
                    ext_hi_next = b;
                end
                if (pos_reg == base + PW'(3)) begin
                    hdr_end_next = (hdr_len > MAX_HDR) ? MAX_POS : hdr_len[PW-1:0];
                end
            end
        end

        // Classify the packet at its final byte
        size   = {2'b00, pos_reg} + SW'(1);
        pad    = pad_flag_next ? b : 8'd0;
        limit  = {2'b00, hdr_end_next} + SW'(pad);
        pend   = size - SW'(pad);
        pstart = '0;

        rpt_beat_next = '0;
        if (!in_range || hdr_end_next == '0) begin
            rpt_beat_next.status = vp8rtp_pkg::ST_DROPPED;
        end
        else if (size <= limit) begin
            rpt_beat_next.status = vp8rtp_pkg::ST_EMPTY;
        end
        else if (phase_next != vp8rtp_pkg::PH_DONE || {2'b00, desc_end_next} > pend) begin
            rpt_beat_next.status = vp8rtp_pkg::ST_OVERRUN;
        end
        else begin
            rpt_beat_next.status        = vp8rtp_pkg::ST_TAKEN;
            pstart                      = {2'b00, desc_end_next};
            rpt_beat_next.payload_start = 12'(pstart);
            rpt_beat_next.payload_end   = 12'(pend);
            if (in_beat_reg.packet_last && pend > pstart) begin
                any_next = 1'b1;
            end
        end

        if (in_beat_reg.packet_last) begin
            // Close the frame or mark it started
            if (in_beat_reg.frame_last) begin
                rpt_beat_next.frame_done         = 1'b1;
                rpt_beat_next.frame_nonempty     = any_next;
                rpt_beat_next.frame_timestamp    = ts_next;
                rpt_beat_next.frame_payload_type = pt_next;
                started_next = 1'b0;
                ts_next      = '0;
                pt_next      = '0;
                any_next     = 1'b0;
            end
            else begin
                started_next = 1'b1;
            end

            // Clear packet state for the next packet
            pos_next      = '0;
            csrc_next     = '0;
            pad_flag_next = 1'b0;
            ext_flag_next = 1'b0;
            ext_hi_next   = '0;
            hdr_end_next  = '0;
            phase_next    = vp8rtp_pkg::PH_FIRST;
            desc_end_next = '0;
            dflags_next   = '0;
        end
    end

    // Input register: load a new beat whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (!pkt_stall) begin
            in_valid_reg <= pkt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && !pkt_stall) begin
            in_beat_reg <= pkt_beat;
        end
    end

    // Result register: load on a packet-final beat, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rpt_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_beat_reg.packet_last) begin
            rpt_valid_reg <= 1'b1;
        end
        else if (!rpt_stall) begin
            rpt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_beat_reg.packet_last) begin
            rpt_beat_reg <= rpt_beat_next;
        end
    end

    // Parse and frame state: advance once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= '0;
            csrc_reg     <= '0;
            pad_flag_reg <= 1'b0;
            ext_flag_reg <= 1'b0;
            ext_hi_reg   <= '0;
            hdr_end_reg  <= '0;
            phase_reg    <= vp8rtp_pkg::PH_FIRST;
            desc_end_reg <= '0;
            dflags_reg   <= '0;
            started_reg  <= 1'b0;
            ts_reg       <= '0;
            pt_reg       <= '0;
            any_reg      <= 1'b0;
        end
        else if (proc_fire) begin
            pos_reg      <= pos_next;
            csrc_reg     <= csrc_next;
            pad_flag_reg <= pad_flag_next;
            ext_flag_reg <= ext_flag_next;
            ext_hi_reg   <= ext_hi_next;
            hdr_end_reg  <= hdr_end_next;
            phase_reg    <= phase_next;
            desc_end_reg <= desc_end_next;
            dflags_reg   <= dflags_next;
            started_reg  <= started_next;
            ts_reg       <= ts_next;
            pt_reg       <= pt_next;
            any_reg      <= any_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vp8_rtp_payload_extractor. Packet bytes go in one
// beat at a time; a scoreboard predicts each packet report from its own
// model of the RTP header and VP8 payload descriptor parse and compares
// every report field. A directed set of packets covers the header, padding,
// descriptor and length corner cases, then random packets run under three
// flow-control mixes, including a long report hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import vp8rtp_pkg::*;

    localparam int MAX_BYTES        = MAX_PACKET_DEFAULT;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 20;
    localparam int BYTES_PER_PHASE  = 700;

    // Predicts one report per packet and checks reports in order
    class report_scoreboard;
        int unsigned byte_pos;
        bit [3:0]    csrc_cnt;
        bit          pad_flag;
        bit          ext_flag;
        bit [15:0]   ext_words;
        int unsigned hdr_end;
        desc_phase_t walk_phase;
        int unsigned desc_end;
        bit [2:0]    desc_flags;
        bit [7:0]    last_byte;
        bit          frame_open;
        bit [31:0]   first_ts;
        bit [6:0]    first_pt;
        bit          frame_has_payload;
        out_beat_t   expected_reports[$];
        int          errors;
        int          frames;
        int          status_seen[4];

        function new();
            clear_packet();
        endfunction

        function void clear_packet();
            byte_pos   = 0;
            csrc_cnt   = '0;
            pad_flag   = 1'b0;
            ext_flag   = 1'b0;
            ext_words  = '0;
            hdr_end    = 0;
            walk_phase = PH_FIRST;
            desc_end   = 0;
            desc_flags = '0;
        endfunction

        // Phase that follows the picture id field
        function desc_phase_t after_pid();
            if (desc_flags[DF_L])
                return PH_TL0;
            if (desc_flags[DF_TK])
                return PH_TK;
            return PH_DONE;
        endfunction

        // Advance the payload descriptor walk by one byte
        function void step_descriptor(bit [7:0] b);
            case (walk_phase)
                PH_FIRST: walk_phase = b[7] ? PH_EXT : PH_DONE;
                PH_EXT:
                begin
                    desc_flags = {b[7], b[6], |b[5:4]};
                    walk_phase = desc_flags[DF_I] ? PH_PID1 : after_pid();
                end
                PH_PID1:  walk_phase = b[7] ? PH_PID2 : after_pid();
                PH_PID2:  walk_phase = after_pid();
                PH_TL0:   walk_phase = desc_flags[DF_TK] ? PH_TK : PH_DONE;
                default:  walk_phase = PH_DONE;
            endcase
        endfunction

        // Fold one in-range packet byte into header and descriptor state
        function void take_byte(int unsigned idx, bit [7:0] b);
            int unsigned base;
            int unsigned hlen;
            if (idx == 0)
            begin
                csrc_cnt = b[3:0];
                pad_flag = b[5];
                ext_flag = b[4];
            end
            if (!frame_open)
            begin
                if (idx == 1)
                    first_pt = b[6:0];
                if (idx >= 4 && idx <= 7)
                    first_ts = {first_ts[23:0], b};
            end
            base = RTP_FIXED_BYTES + 4 * csrc_cnt;
            if (hdr_end != 0)
            begin
                if (idx >= hdr_end && walk_phase != PH_DONE)
                begin
                    step_descriptor(b);
                    desc_end = idx + 1;
                end
            end
            else if (!ext_flag)
            begin
                if (idx + 1 == base)
                    hdr_end = base;
            end
            else
            begin
                if (idx == base + 2)
                    ext_words = {b, 8'h00};
                if (idx == base + 3)
                begin
                    ext_words[7:0] = b;
                    hlen = base + 4 + 4 * ext_words;
                    hdr_end = (hlen > MAX_BYTES) ? MAX_BYTES : hlen;
                end
            end
        endfunction

        // Note an accepted byte; queue the report a packet end produces
        function void note_byte(in_beat_t beat);
            int unsigned idx;
            int unsigned pkt_len;
            int unsigned pad_len;
            int unsigned pl_end;
            bit          too_long;
            out_beat_t   rep;
            idx       = byte_pos;
            too_long  = 1'b0;
            last_byte = beat.data_byte;
            if (idx < MAX_BYTES)
            begin
                take_byte(idx, beat.data_byte);
                byte_pos = idx + 1;
            end
            else
                too_long = 1'b1;
            if (!beat.packet_last)
                return;

            rep = '0;
            if (too_long || hdr_end == 0)
                rep.status = ST_DROPPED;
            else
            begin
                pkt_len = idx + 1;
                pad_len = pad_flag ? last_byte : 0;
                if (pkt_len <= hdr_end + pad_len)
                    rep.status = ST_EMPTY;
                else
                begin
                    pl_end = pkt_len - pad_len;
                    if (walk_phase != PH_DONE || desc_end > pl_end)
                        rep.status = ST_OVERRUN;
                    else
                    begin
                        rep.status        = ST_TAKEN;
                        rep.payload_start = desc_end[11:0];
                        rep.payload_end   = pl_end[11:0];
                        if (pl_end > desc_end)
                            frame_has_payload = 1'b1;
                    end
                end
            end

            // Close the frame or keep its first-packet fields
            if (beat.frame_last)
            begin
                rep.frame_done         = 1'b1;
                rep.frame_nonempty     = frame_has_payload;
                rep.frame_timestamp    = first_ts;
                rep.frame_payload_type = first_pt;
                frame_open        = 1'b0;
                first_ts          = '0;
                first_pt          = '0;
                frame_has_payload = 1'b0;
                frames++;
            end
            else
                frame_open = 1'b1;

            status_seen[rep.status]++;
            expected_reports.push_back(rep);
            clear_packet();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, want, seen);
            end
        endfunction

        // Check an accepted report against the oldest prediction
        function void check_report(out_beat_t got);
            out_beat_t want;
            if (expected_reports.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected report: expected none, actual %h", $time, got);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("payload_start", 32'(want.payload_start), 32'(got.payload_start));
            compare_field("payload_end", 32'(want.payload_end), 32'(got.payload_end));
            compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            compare_field("frame_nonempty", 32'(want.frame_nonempty),
                          32'(got.frame_nonempty));
            compare_field("frame_timestamp", want.frame_timestamp, got.frame_timestamp);
            compare_field("frame_payload_type", 32'(want.frame_payload_type),
                          32'(got.frame_payload_type));
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      pkt_valid = 1'b0;
    logic      pkt_stall;
    in_beat_t  pkt_beat  = '0;
    logic      rpt_valid;
    logic      rpt_stall = 1'b0;
    out_beat_t rpt_beat;

    report_scoreboard sb;
    int       tx_idle_pct;
    int       rx_idle_pct;
    bit       hold_req;
    int       bytes_sent;
    bit [7:0] pkt_bytes[$];

    vp8_rtp_payload_extractor #(
        .MAX_PACKET(MAX_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt_beat  (pkt_beat),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt_beat  (rpt_beat)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Take reports; stall at random or for a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rpt_valid && !rpt_stall)
                sb.check_report(rpt_beat);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
                hold_left--;
            rpt_stall <= (hold_left > 0) || ($urandom_range(99) < rx_idle_pct);
        end
    end

    // End the run when no beat moves on either channel for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pkt_valid && !pkt_stall) || (rpt_valid && !rpt_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout with %0d reports outstanding", $time,
                 sb.expected_reports.size());
        $display("** vp8_rtp_payload_extractor: FAILED **");
        $finish;
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_beat(in_beat_t beat);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pkt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_valid <= 1'b1;
        pkt_beat  <= beat;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        sb.note_byte(beat);
        bytes_sent++;
    endtask

    // Send the bytes in pkt_bytes as one packet; optionally add stray frame marks
    task automatic send_packet(bit flast, bit stray);
        in_beat_t beat;
        int       n;
        n = pkt_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            beat.data_byte   = pkt_bytes[i];
            beat.packet_last = (i == n - 1);
            beat.frame_last  = (i == n - 1) ? flast : (stray && $urandom_range(7) == 0);
            send_beat(beat);
        end
    endtask

    // Pause the sender until every predicted report has arrived
    task automatic drain();
        pkt_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
    endtask

    // Start a packet: first header byte, then the rest of the header and CSRCs
    task automatic put_header(bit [7:0] b0, bit [7:0] fill);
        pkt_bytes.delete();
        pkt_bytes.push_back(b0);
        repeat (11 + 4 * b0[3:0]) pkt_bytes.push_back(fill);
    endtask

    // Build a random packet; mostly well formed, some truncated or noise
    task automatic build_packet(bit broken);
        int       cc;
        int       xlen;
        int       npad;
        int       keep;
        bit [7:0] b0;
        bit [7:0] dx;
        bit [7:0] pid;
        bit [7:0] d0;
        cc = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(2);
        b0 = 8'($urandom);
        b0[5] = ($urandom_range(3) == 0);
        b0[4] = ($urandom_range(3) == 0);
        b0[3:0] = 4'(cc);
        pkt_bytes.delete();
        pkt_bytes.push_back(b0);
        repeat (11 + 4 * cc) pkt_bytes.push_back(8'($urandom));

        // Header extension, now and then with a length past the packet limit
        if (b0[4])
        begin
            xlen = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(3);
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'(xlen >> 8));
            pkt_bytes.push_back(8'(xlen));
            if (xlen <= 3)
                repeat (4 * xlen) pkt_bytes.push_back(8'($urandom));
        end

        // VP8 payload descriptor with random optional fields
        d0 = 8'($urandom);
        pkt_bytes.push_back(d0);
        if (d0[7])
        begin
            dx = 8'($urandom);
            pkt_bytes.push_back(dx);
            if (dx[7])
            begin
                pid = 8'($urandom);
                pkt_bytes.push_back(pid);
                if (pid[7])
                    pkt_bytes.push_back(8'($urandom));
            end
            if (dx[6])
                pkt_bytes.push_back(8'($urandom));
            if (|dx[5:4])
                pkt_bytes.push_back(8'($urandom));
        end

        if ($urandom_range(3) != 0)
            repeat ($urandom_range(1, 24)) pkt_bytes.push_back(8'($urandom));

        if (b0[5])
        begin
            npad = $urandom_range(1, 6);
            repeat (npad - 1) pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'(npad));
        end

        // Break it: cut short, corrupt the final byte, or replace with noise
        if (broken)
        begin
            case ($urandom_range(2))
                0:
                begin
                    keep = $urandom_range(1, pkt_bytes.size());
                    while (pkt_bytes.size() > keep)
                        void'(pkt_bytes.pop_back());
                end
                1: pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom);
                default:
                begin
                    pkt_bytes.delete();
                    repeat ($urandom_range(1, 40)) pkt_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endtask

    initial
    begin
        int target;
        sb = new();
        tx_idle_pct = 8;
        rx_idle_pct = 56;
        hold_req    = 1'b0;
        bytes_sent  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short first packet: timestamp takes only the bytes that arrived
        pkt_bytes = '{8'h80, 8'h7F, 8'h12, 8'h34, 8'hAB};
        send_packet(1'b0, 1'b0);
        put_header(8'h80, 8'hFF);
        pkt_bytes.push_back(8'h10);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        send_packet(1'b1, 1'b0);

        // Header only, then descriptor ending exactly at payload end
        put_header(8'h80, 8'hFF);
        send_packet(1'b1, 1'b0);
        put_header(8'h80, 8'h00);
        pkt_bytes.push_back(8'h00);
        send_packet(1'b1, 1'b0);

        // Full descriptor with CSRCs: I with long picture id, L, T and K
        put_header(8'h82, 8'h5A);
        pkt_bytes = {pkt_bytes, 8'h80, 8'hF0, 8'hFF, 8'hFF, 8'h01, 8'h02,
                     8'hFF, 8'h00, 8'h81};
        send_packet(1'b0, 1'b0);

        // Descriptor runs past the end of the packet
        put_header(8'h80, 8'hA5);
        pkt_bytes = {pkt_bytes, 8'h90, 8'hC0, 8'h7F};
        send_packet(1'b1, 1'b0);

        // Padding larger than the packet, then padding that fits
        put_header(8'hA0, 8'h33);
        pkt_bytes = {pkt_bytes, 8'h00, 8'h44, 8'hFF};
        send_packet(1'b0, 1'b0);
        put_header(8'hA0, 8'h33);
        pkt_bytes = {pkt_bytes, 8'h00, 8'h11, 8'h22, 8'h00, 8'h02};
        send_packet(1'b1, 1'b0);

        // Extension cut before its length, maximum length, ordinary length
        put_header(8'h90, 8'h00);
        pkt_bytes = {pkt_bytes, 8'hBE, 8'hDE};
        send_packet(1'b0, 1'b0);
        put_header(8'h9F, 8'hFF);
        pkt_bytes = {pkt_bytes, 8'hBE, 8'hDE, 8'hFF, 8'hFF};
        repeat (10) pkt_bytes.push_back(8'($urandom));
        send_packet(1'b1, 1'b0);
        put_header(8'h90, 8'h00);
        pkt_bytes = {pkt_bytes, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03,
                     8'h04, 8'h00, 8'hEE};
        send_packet(1'b0, 1'b0);

        // Packet of exactly the limit, then one two bytes longer with stray frame marks
        put_header(8'h80, 8'h00);
        pkt_bytes.push_back(8'h00);
        while (pkt_bytes.size() < MAX_BYTES)
            pkt_bytes.push_back(8'($urandom));
        send_packet(1'b0, 1'b0);
        put_header(8'h80, 8'h00);
        pkt_bytes.push_back(8'h00);
        while (pkt_bytes.size() < MAX_BYTES + 2)
            pkt_bytes.push_back(8'($urandom));
        send_packet(1'b1, 1'b1);
        drain();

        // Random packets under three idle mixes; long report hold-off first
        for (int mix = 0; mix < 3; mix++)
        begin
            tx_idle_pct = (mix == 0) ? 8 : (mix == 1) ? 56 : 0;
            rx_idle_pct = (mix == 0) ? 56 : (mix == 1) ? 8 : 0;
            if (mix == 0)
                hold_req = 1'b1;
            target = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < target)
            begin
                build_packet($urandom_range(99) < 15);
                send_packet($urandom_range(2) == 0, 1'b1);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d bytes in %0d packets, %0d frames closed.",
                 bytes_sent, sb.status_seen[0] + sb.status_seen[1] +
                 sb.status_seen[2] + sb.status_seen[3], sb.frames);
        $display("Reports: %0d taken, %0d empty, %0d overrun, %0d dropped.",
                 sb.status_seen[ST_TAKEN], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_OVERRUN], sb.status_seen[ST_DROPPED]);
        if (sb.errors == 0)
            $display("** vp8_rtp_payload_extractor: PASSED **");
        else
            $display("** vp8_rtp_payload_extractor: FAILED **");
        $finish;
    end

endmodule
